// ===== rtl/core/exr_pkg.sv =====
// ----------------------------------------------------------------------------
// exr_pkg
// Shared constants and helpers for the Euler X-Y-Z vector rotator: CORDIC
// arctangent table, gain and angle range reduction.
// ----------------------------------------------------------------------------
package exr_pkg;

  localparam int ANGLE_W      = 17;
  localparam int CFG_IDX_W    = 2;
  localparam int COORD_W      = 32;
  localparam int CORDIC_STEPS = 28;
  localparam int STEP_W       = 5;
  localparam int CORDIC_W     = 34;  // Q2.30 datapath with headroom
  localparam int ZW           = 32;  // residual angle, 1/(100*65536) degree
  localparam int RED_W        = 15;  // reduced angle, within +-9000
  localparam int ANG_SCALE    = 16;

  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_Z = 2'd2;

  typedef struct packed {
    logic                    neg;
    logic signed [RED_W-1:0] ang;
  } red_angle_t;

  // atan(2^-i) in units of 1/(100*65536) degree
  function automatic logic signed [ZW-1:0] atan_val(input logic [STEP_W-1:0] i);
    logic signed [ZW-1:0] r;
    unique case (i)
      5'd0:  r = 32'sd294912000;
      5'd1:  r = 32'sd174096719;
      5'd2:  r = 32'sd91987925;
      5'd3:  r = 32'sd46694507;
      5'd4:  r = 32'sd23437865;
      5'd5:  r = 32'sd11730358;
      5'd6:  r = 32'sd5866610;
      5'd7:  r = 32'sd2933484;
      5'd8:  r = 32'sd1466764;
      5'd9:  r = 32'sd733385;
      5'd10: r = 32'sd366693;
      5'd11: r = 32'sd183346;
      5'd12: r = 32'sd91673;
      5'd13: r = 32'sd45837;
      5'd14: r = 32'sd22918;
      5'd15: r = 32'sd11459;
      5'd16: r = 32'sd5730;
      5'd17: r = 32'sd2865;
      5'd18: r = 32'sd1432;
      5'd19: r = 32'sd716;
      5'd20: r = 32'sd358;
      5'd21: r = 32'sd179;
      5'd22: r = 32'sd90;
      5'd23: r = 32'sd45;
      5'd24: r = 32'sd22;
      5'd25: r = 32'sd11;
      5'd26: r = 32'sd6;
      5'd27: r = 32'sd3;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Wrap an angle into one turn, then fold it into a quarter turn either side
  function automatic red_angle_t reduce_angle(input logic signed [ANGLE_W-1:0] a);
    logic signed [18:0] t;
    red_angle_t         r;
    t = 19'(a);
    if (t < 0) t = t + 19'sd72000;
    if (t >= 19'sd36000) t = t - 19'sd36000;
    if (t >= 19'sd36000) t = t - 19'sd36000;
    if (t >= 19'sd36000) t = t - 19'sd36000;
    if (t > 19'sd18000) t = t - 19'sd36000;
    r.neg = 1'b0;
    if (t > 19'sd9000) begin
      t     = t - 19'sd18000;
      r.neg = 1'b1;
    end else if (t < -19'sd9000) begin
      t     = t + 19'sd18000;
      r.neg = 1'b1;
    end
    r.ang = t[RED_W-1:0];
    return r;
  endfunction

endpackage

// ===== rtl/core/euler_xyz_vector_rotate.sv =====
// ----------------------------------------------------------------------------
// euler_xyz_vector_rotate
// Rotates a Q16.16 vector about X, then Y, then Z by configured angles.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall carries one vector (in_x, in_y, in_z);
//   output channel out_valid/out_stall returns the rotated vector and a
//   saturated flag. A transaction completes when valid is high and stall low.
//   Angles (hundredths of a degree) are written on cfg_we/cfg_index/cfg_wdata.
// Latency and throughput:
//   Six register stages from an accepted input to out_valid; one vector per
//   cycle is sustained if in_stall is low. Each stage holds its item while the
//   next stage is full and blocked, so bubbles close up under an output stall.
// Sine/cosine:
//   A shared 28-step CORDIC computes sine and cosine of the three angles one
//   after the other, after reset and after every angle write. in_stall stays
//   high during that time.
// Reset:
//   rst_n (synchronous, active low) clears angles to zero, empties the
//   pipeline and starts the sine/cosine computation.
// ----------------------------------------------------------------------------
module euler_xyz_vector_rotate #(
  parameter int TRIG_FRAC_BITS = 30
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [exr_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [exr_pkg::ANGLE_W-1:0]            cfg_wdata,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [exr_pkg::COORD_W-1:0]     in_x,
  input  logic signed [exr_pkg::COORD_W-1:0]     in_y,
  input  logic signed [exr_pkg::COORD_W-1:0]     in_z,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [exr_pkg::COORD_W-1:0]     out_x,
  output logic signed [exr_pkg::COORD_W-1:0]     out_y,
  output logic signed [exr_pkg::COORD_W-1:0]     out_z,
  output logic                                   saturated
);

  localparam int TW      = TRIG_FRAC_BITS + 2;
  localparam int TRIG_SH = 30 - TRIG_FRAC_BITS;
  localparam int IW      = exr_pkg::COORD_W + 2;
  localparam int PW      = IW + TW;
  localparam int SW      = PW + 1;
  localparam int CW      = exr_pkg::CORDIC_W;

  typedef enum logic [1:0] {S_IDLE, S_LOAD, S_ITER} cstate_t;

  // --------------------------------------------------------------------------
  // Angle registers
  // --------------------------------------------------------------------------
  logic signed [exr_pkg::ANGLE_W-1:0] ang_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ang_r[0] <= '0;
      ang_r[1] <= '0;
      ang_r[2] <= '0;
    end else if (cfg_we) begin
      if (cfg_index == exr_pkg::REG_ANGLE_X) ang_r[0] <= cfg_wdata;
      if (cfg_index == exr_pkg::REG_ANGLE_Y) ang_r[1] <= cfg_wdata;
      if (cfg_index == exr_pkg::REG_ANGLE_Z) ang_r[2] <= cfg_wdata;
    end
  end

  // --------------------------------------------------------------------------
  // Shared CORDIC sequencer for sine and cosine
  // --------------------------------------------------------------------------
  cstate_t                          cst_r;
  logic [1:0]                       axis_r;
  logic [exr_pkg::STEP_W-1:0]       step_r;
  logic signed [CW-1:0]             cx_r, cy_r;
  logic signed [exr_pkg::ZW-1:0]    cz_r;
  logic                             cneg_r;
  logic signed [TW-1:0]             sin_r [3];
  logic signed [TW-1:0]             cos_r [3];
  exr_pkg::red_angle_t              red;
  logic signed [CW-1:0]             dx, dy, fx, fy, cx_nxt, cy_nxt;
  logic signed [exr_pkg::ZW-1:0]    atan_s;
  logic signed [TW-1:0]             cos_q, sin_q;

  assign red    = exr_pkg::reduce_angle(ang_r[axis_r]);
  assign dx     = cy_r >>> step_r;
  assign dy     = cx_r >>> step_r;
  assign atan_s = exr_pkg::atan_val(step_r);
  assign cx_nxt = (cz_r >= 0) ? cx_r - dx : cx_r + dx;
  assign cy_nxt = (cz_r >= 0) ? cy_r + dy : cy_r - dy;
  assign fx     = cneg_r ? -cx_nxt : cx_nxt;
  assign fy     = cneg_r ? -cy_nxt : cy_nxt;

  // Round the Q2.30 result to the trig fraction width
  generate
    if (TRIG_SH == 0) begin : g_trig_exact
      assign cos_q = TW'(fx);
      assign sin_q = TW'(fy);
    end else begin : g_trig_round
      logic signed [CW-1:0] rc, rs;
      assign rc    = (fx + (CW'(1) <<< (TRIG_SH - 1))) >>> TRIG_SH;
      assign rs    = (fy + (CW'(1) <<< (TRIG_SH - 1))) >>> TRIG_SH;
      assign cos_q = TW'(rc);
      assign sin_q = TW'(rs);
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cst_r  <= S_LOAD;
      axis_r <= '0;
      step_r <= '0;
    end else if (cfg_we) begin
      cst_r  <= S_LOAD;
      axis_r <= '0;
      step_r <= '0;
    end else begin
      unique case (cst_r)
        S_IDLE: ;
        S_LOAD: begin
          cx_r   <= exr_pkg::CORDIC_GAIN;
          cy_r   <= '0;
          cz_r   <= exr_pkg::ZW'(red.ang) <<< exr_pkg::ANG_SCALE;
          cneg_r <= red.neg;
          step_r <= '0;
          cst_r  <= S_ITER;
        end
        S_ITER: begin
          cx_r <= cx_nxt;
          cy_r <= cy_nxt;
          cz_r <= (cz_r >= 0) ? cz_r - atan_s : cz_r + atan_s;
          if (step_r == exr_pkg::STEP_W'(exr_pkg::CORDIC_STEPS - 1)) begin
            cos_r[axis_r] <= cos_q;
            sin_r[axis_r] <= sin_q;
            if (axis_r == 2'd2) begin
              cst_r <= S_IDLE;
            end else begin
              axis_r <= axis_r + 2'd1;
              cst_r  <= S_LOAD;
            end
          end else begin
            step_r <= step_r + 1'b1;
          end
        end
        default: cst_r <= S_IDLE;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Rotation pipeline helpers
  // --------------------------------------------------------------------------
  function automatic logic signed [IW-1:0] rnd(input logic signed [SW-1:0] s);
    logic signed [SW-1:0] t;
    t = (s + (SW'(1) <<< (TRIG_FRAC_BITS - 1))) >>> TRIG_FRAC_BITS;
    return IW'(t);
  endfunction

  function automatic logic ovf(input logic signed [IW-1:0] v);
    return (v[IW-1:exr_pkg::COORD_W-1] != '0) && (v[IW-1:exr_pkg::COORD_W-1] != '1);
  endfunction

  function automatic logic signed [exr_pkg::COORD_W-1:0] clip(
      input logic signed [IW-1:0] v);
    logic signed [exr_pkg::COORD_W-1:0] r;
    if (!ovf(v))      r = v[exr_pkg::COORD_W-1:0];
    else if (v[IW-1]) r = {1'b1, {(exr_pkg::COORD_W-1){1'b0}}};
    else              r = {1'b0, {(exr_pkg::COORD_W-1){1'b1}}};
    return r;
  endfunction

  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;
  logic busy;

  assign busy     = (cst_r != S_IDLE);
  assign rdy6     = !v6_r || !out_stall;
  assign rdy5     = !v5_r || rdy6;
  assign rdy4     = !v4_r || rdy5;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_stall = busy || !rdy1;

  logic signed [IW-1:0] x1_r, x2s_r, y1_r, z1_r, y1b_r, x2_r, z2_r, z2b_r;
  logic signed [PW-1:0] p1a_r, p1b_r, p1c_r, p1d_r;
  logic signed [PW-1:0] p3a_r, p3b_r, p3c_r, p3d_r;
  logic signed [PW-1:0] p5a_r, p5b_r, p5c_r, p5d_r;
  logic signed [IW-1:0] yi, zi, x3, y3;

  assign yi = IW'(in_y);
  assign zi = IW'(in_z);
  assign x3 = rnd(SW'(p5a_r) - SW'(p5b_r));
  assign y3 = rnd(SW'(p5c_r) + SW'(p5d_r));

  // Advance valid bits wherever the next stage can take the item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0;
      v4_r <= 1'b0; v5_r <= 1'b0; v6_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid && !busy;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
      if (rdy6) v6_r <= v5_r;
    end
  end

  // Stage 1: X rotation products
  always_ff @(posedge clk) begin
    if (rdy1) begin
      x1_r  <= IW'(in_x);
      p1a_r <= yi * cos_r[0];
      p1b_r <= zi * sin_r[0];
      p1c_r <= yi * sin_r[0];
      p1d_r <= zi * cos_r[0];
    end
  end

  // Stage 2: y1, z1
  always_ff @(posedge clk) begin
    if (rdy2) begin
      x2s_r <= x1_r;
      y1_r  <= rnd(SW'(p1a_r) - SW'(p1b_r));
      z1_r  <= rnd(SW'(p1c_r) + SW'(p1d_r));
    end
  end

  // Stage 3: Y rotation products
  always_ff @(posedge clk) begin
    if (rdy3) begin
      y1b_r <= y1_r;
      p3a_r <= x2s_r * cos_r[1];
      p3b_r <= z1_r * sin_r[1];
      p3c_r <= z1_r * cos_r[1];
      p3d_r <= x2s_r * sin_r[1];
    end
  end

  // Stage 4: x2, z2
  always_ff @(posedge clk) begin
    if (rdy4) begin
      x2_r <= rnd(SW'(p3a_r) + SW'(p3b_r));
      z2_r <= rnd(SW'(p3c_r) - SW'(p3d_r));
    end
  end

  logic signed [IW-1:0] y1c_r;
  always_ff @(posedge clk) begin
    if (rdy4) y1c_r <= y1b_r;
  end

  // Stage 5: Z rotation products
  always_ff @(posedge clk) begin
    if (rdy5) begin
      z2b_r <= z2_r;
      p5a_r <= x2_r * cos_r[2];
      p5b_r <= y1c_r * sin_r[2];
      p5c_r <= x2_r * sin_r[2];
      p5d_r <= y1c_r * cos_r[2];
    end
  end

  // Stage 6: round, saturate and hold for the receiver
  always_ff @(posedge clk) begin
    if (rdy6) begin
      out_x     <= clip(x3);
      out_y     <= clip(y3);
      out_z     <= clip(z2b_r);
      saturated <= ovf(x3) || ovf(y3) || ovf(z2b_r);
    end
  end

  assign out_valid = v6_r;

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Euler X-Y-Z vector rotator. A built-in
// CORDIC and fixed-point rotation predicts every vector. Directed cases cover
// angle wrap and fold, field extremes and saturation. Random phases use new
// angles and random idling on both sides; one test holds the output off long.
// ----------------------------------------------------------------------------
module tb;

  localparam int  TRIG_FRAC   = 30;
  localparam int  CYCLE_LIMIT = 600000;
  localparam int  HOLD_CYCLES = 200;

  typedef struct {
    logic signed [exr_pkg::COORD_W-1:0] x;
    logic signed [exr_pkg::COORD_W-1:0] y;
    logic signed [exr_pkg::COORD_W-1:0] z;
    logic                               sat;
  } rotated_t;

  logic                                 clk;
  logic                                 rst_n;
  logic                                 cfg_we;
  logic [exr_pkg::CFG_IDX_W-1:0]        cfg_index;
  logic [exr_pkg::ANGLE_W-1:0]          cfg_wdata;
  logic                                 in_valid;
  logic                                 in_stall;
  logic signed [exr_pkg::COORD_W-1:0]   in_x, in_y, in_z;
  logic                                 out_valid;
  logic                                 out_stall;
  logic signed [exr_pkg::COORD_W-1:0]   out_x, out_y, out_z;
  logic                                 saturated;

  rotated_t  rotated_q[$];
  int        angle_deg100[3];
  int        mismatches;
  int        cycles;
  bit        calm;       // no idling on either side
  bit        hold_req;
  int        hold_left;
  int        stall_left;

  euler_xyz_vector_rotate #(.TRIG_FRAC_BITS(TRIG_FRAC)) uut (.*);

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor
  function automatic longint round_shr(longint v, int n);
    if (n == 0) return v;
    return (v + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic longint atan_step(int i);
    longint t[exr_pkg::CORDIC_STEPS] = '{
      294912000, 174096719, 91987925, 46694507, 23437865, 11730358,
      5866610, 2933484, 1466764, 733385, 366693, 183346, 91673, 45837,
      22918, 11459, 5730, 2865, 1432, 716, 358, 179, 90, 45, 22, 11, 6, 3};
    return t[i];
  endfunction

  task automatic sin_cos(input int ang, output longint s, output longint c);
    int     a;
    bit     flip;
    longint cx, sy, z, dx, dy;
    a = ang;
    flip = 1'b0;
    cx = 652032874;
    sy = 0;
    if (a < 0) a += 72000;
    a = a % 36000;
    if (a > 18000) a -= 36000;
    if (a > 9000) begin
      a -= 18000;
      flip = 1'b1;
    end else if (a < -9000) begin
      a += 18000;
      flip = 1'b1;
    end
    z = longint'(a) <<< exr_pkg::ANG_SCALE;
    for (int i = 0; i < exr_pkg::CORDIC_STEPS; i++) begin
      dx = sy >>> i;
      dy = cx >>> i;
      if (z >= 0) begin
        cx -= dx; sy += dy; z -= atan_step(i);
      end else begin
        cx += dx; sy -= dy; z += atan_step(i);
      end
    end
    if (flip) begin
      cx = -cx; sy = -sy;
    end
    c = round_shr(cx, 30 - TRIG_FRAC);
    s = round_shr(sy, 30 - TRIG_FRAC);
  endtask

  function automatic logic signed [exr_pkg::COORD_W-1:0] clip(longint v, ref logic sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1; return 32'sh7fffffff;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1; return 32'sh80000000;
    end
    return v[exr_pkg::COORD_W-1:0];
  endfunction

  task automatic rotate_xyz(input logic signed [exr_pkg::COORD_W-1:0] vx, vy, vz,
                            output rotated_t r);
    longint sx, cx, sy, cy, sz, cz, x, y, z, y1, z1, x2, z2, x3, y3;
    logic   sat;
    sin_cos(angle_deg100[0], sx, cx);
    sin_cos(angle_deg100[1], sy, cy);
    sin_cos(angle_deg100[2], sz, cz);
    x = vx; y = vy; z = vz;
    y1 = round_shr(y * cx - z * sx, TRIG_FRAC);
    z1 = round_shr(y * sx + z * cx, TRIG_FRAC);
    x2 = round_shr(x * cy + z1 * sy, TRIG_FRAC);
    z2 = round_shr(z1 * cy - x * sy, TRIG_FRAC);
    x3 = round_shr(x2 * cz - y1 * sz, TRIG_FRAC);
    y3 = round_shr(x2 * sz + y1 * cz, TRIG_FRAC);
    sat = 1'b0;
    r.x = clip(x3, sat);
    r.y = clip(y3, sat);
    r.z = clip(z2, sat);
    r.sat = sat;
  endtask

  // ------------------------------------------------------ result side / check
  always @(posedge clk) begin
    rotated_t e;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (rotated_q.size() == 0) begin
          $error("unexpected transaction x=%0d y=%0d z=%0d", out_x, out_y, out_z);
          mismatches++;
        end else begin
          e = rotated_q.pop_front();
          if (out_x !== e.x) begin
            $error("out_x expected %0d actual %0d", e.x, out_x); mismatches++;
          end
          if (out_y !== e.y) begin
            $error("out_y expected %0d actual %0d", e.y, out_y); mismatches++;
          end
          if (out_z !== e.z) begin
            $error("out_z expected %0d actual %0d", e.z, out_z); mismatches++;
          end
          if (saturated !== e.sat) begin
            $error("saturated expected %0b actual %0b", e.sat, saturated);
            mismatches++;
          end
        end
        stall_left = calm ? 0 : $urandom_range(0, 8);
      end
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      // hold off first, then the per-transaction stall
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------ input side
  task automatic send_vector(input logic signed [exr_pkg::COORD_W-1:0] vx, vy, vz);
    rotated_t r;
    int       gap;
    gap = calm ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_x <= vx;
    in_y <= vy;
    in_z <= vz;
    do @(posedge clk); while (in_stall);
    rotate_xyz(vx, vy, vz, r);
    rotated_q.push_back(r);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (rotated_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_angles(input int ax, ay, az);
    int a[3];
    a = '{ax, ay, az};
    drain();
    for (int i = 0; i < 3; i++) begin
      @(posedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= (i == 0) ? exr_pkg::REG_ANGLE_X :
                   (i == 1) ? exr_pkg::REG_ANGLE_Y : exr_pkg::REG_ANGLE_Z;
      cfg_wdata <= a[i][exr_pkg::ANGLE_W-1:0];
      angle_deg100[i] = int'(signed'(a[i][exr_pkg::ANGLE_W-1:0]));
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [exr_pkg::COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(0, 32'h3ffff) - 32'h20000;
      1:       return $urandom();
      2:       return $urandom() >>> $urandom_range(0, 31);
      default: return $urandom_range(0, 1) ? 32'sh7fffffff - $urandom_range(0, 9)
                                           : 32'sh80000000 + $urandom_range(0, 9);
    endcase
  endfunction

  function automatic int rand_angle();
    if ($urandom_range(0, 4) == 0) return $urandom_range(0, 131071) - 65536;
    return $urandom_range(0, 72000) - 36000;
  endfunction

  // ----------------------------------------------------------------- tests
  task automatic test_field_extremes;
    logic signed [exr_pkg::COORD_W-1:0] v[5] = '{32'sh7fffffff, 32'sh80000000, 0, 1, -1};
    set_angles(0, 0, 0);
    for (int i = 0; i < 5; i++) send_vector(v[i], v[(i + 1) % 5], v[(i + 2) % 5]);
    set_angles(3000, -4500, 12345);
    send_vector(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
    send_vector(32'sh00010000, 32'sh00020000, -32'sh00030000);
  endtask

  // wrap past one turn, fold past a quarter turn, and both 17-bit extremes
  task automatic test_angle_wrap_fold;
    int set[7][3] = '{'{36000, -36000, 0}, '{9000, -9000, 18000},
                      '{9001, -9001, 27000}, '{65535, -65536, 17999},
                      '{-18000, 35999, -27000}, '{0, 0, 4500},
                      '{-65536, 65535, -1}};
    foreach (set[i]) begin
      set_angles(set[i][0], set[i][1], set[i][2]);
      send_vector(32'sh7fffffff, 32'sh7fffffff, 32'sh0);
      send_vector(32'sh80000000, 32'sh12345678, -32'sh0abcdef0);
    end
  endtask

  task automatic test_random_phases;
    for (int p = 0; p < 16; p++) begin
      set_angles(rand_angle(), rand_angle(), rand_angle());
      calm = (p % 4 == 3);
      for (int i = 0; i < 100; i++) send_vector(rand_coord(), rand_coord(), rand_coord());
      calm = 1'b0;
    end
  endtask

  // hold the output side while the input keeps offering back to back
  task automatic test_output_hold_off;
    set_angles(rand_angle(), rand_angle(), rand_angle());
    @(posedge clk);
    hold_req = 1'b1;
    calm = 1'b1;
    for (int i = 0; i < 40; i++) send_vector(rand_coord(), rand_coord(), rand_coord());
    calm = 1'b0;
  endtask

  initial begin
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = exr_pkg::REG_ANGLE_X;
    cfg_wdata  = '0;
    in_valid   = 1'b0;
    in_x       = '0;
    in_y       = '0;
    in_z       = '0;
    calm       = 1'b0;
    hold_req   = 1'b0;
    mismatches = 0;
    cycles     = 0;
    angle_deg100 = '{0, 0, 0};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_field_extremes();
    test_angle_wrap_fold();
    test_output_hold_off();
    test_random_phases();

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/exr_pkg.sv
rtl/core/euler_xyz_vector_rotate.sv
tb/tb.sv
